// ===== sv/mlfr_pkg.sv =====
package mlfr_pkg;

    localparam logic [7:0] MAGIC_DATA = 8'hA5;
    localparam logic [7:0] MAGIC_CMD  = 8'hA6;
    localparam logic [7:0] MAGIC_RAW  = 8'hA7;
    localparam logic [7:0] PAIR_DATA  = 8'h5A;
    localparam logic [7:0] PAIR_CMD   = 8'h5B;
    localparam logic [7:0] PAIR_RAW   = 8'h7A;

    localparam logic [12:0] PAYLOAD_CAP = 13'd4096;

    localparam logic [12:0] MAX_PAYLOAD_RST   = 13'd1024;
    localparam logic [15:0] DISCARD_LIMIT_RST = 16'd4096;

    localparam logic [1:0] KIND_PAYLOAD    = 2'd0;
    localparam logic [1:0] KIND_EMPTY      = 2'd1;
    localparam logic [1:0] KIND_BAD_HEADER = 2'd2;
    localparam logic [1:0] KIND_BAD_LENGTH = 2'd3;

    localparam logic [1:0] TYPE_DATA = 2'd0;
    localparam logic [1:0] TYPE_CMD  = 2'd1;
    localparam logic [1:0] TYPE_RAW  = 2'd2;

    localparam logic REG_MAX_PAYLOAD   = 1'b0;
    localparam logic REG_DISCARD_LIMIT = 1'b1;

    typedef struct packed {
        logic [12:0] max_payload;
        logic [15:0] discard_limit;
    } mlfr_cfg_t;

    typedef struct packed {
        logic [1:0]  event_kind;
        logic [1:0]  frame_type;
        logic [7:0]  payload_byte;
        logic        last_byte;
        logic [15:0] payload_length;
    } mlfr_result_t;

    function automatic logic is_first(input logic [7:0] b);
        return (b == MAGIC_DATA) || (b == MAGIC_CMD) || (b == MAGIC_RAW);
    endfunction

    function automatic logic pair_ok(input logic [7:0] a, input logic [7:0] b);
        return ((a == MAGIC_DATA) && (b == PAIR_DATA)) ||
               ((a == MAGIC_CMD) && (b == PAIR_CMD)) ||
               ((a == MAGIC_RAW) && (b == PAIR_RAW));
    endfunction

    function automatic logic [1:0] type_of(input logic [7:0] m);
        logic [1:0] t;
        if (m == MAGIC_CMD)
        begin
            t = TYPE_CMD;
        end
        else if (m == MAGIC_RAW)
        begin
            t = TYPE_RAW;
        end
        else
        begin
            t = TYPE_DATA;
        end
        return t;
    endfunction

endpackage

// ===== sv/mlfr_cfg_regs.sv =====
module mlfr_cfg_regs (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output mlfr_pkg::mlfr_cfg_t cfg
);
    import mlfr_pkg::*;

    logic [12:0] max_payload_reg;
    logic [15:0] discard_limit_reg;
    logic        wr_en;
    logic        reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg   <= MAX_PAYLOAD_RST;
            discard_limit_reg <= DISCARD_LIMIT_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_MAX_PAYLOAD:   max_payload_reg   <= pwdata[12:0];
                REG_DISCARD_LIMIT: discard_limit_reg <= pwdata[15:0];
                default:           max_payload_reg   <= max_payload_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_MAX_PAYLOAD:   prdata = {19'd0, max_payload_reg};
            REG_DISCARD_LIMIT: prdata = {16'd0, discard_limit_reg};
            default:           prdata = '0;
        endcase
    end

    assign cfg.max_payload   = max_payload_reg;
    assign cfg.discard_limit = discard_limit_reg;

endmodule

// ===== sv/mlfr_parser.sv =====
module mlfr_parser (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic [7:0]             rx_byte,
    input  mlfr_pkg::mlfr_cfg_t    cfg,
    output logic                   res_valid,
    output mlfr_pkg::mlfr_result_t res
);
    import mlfr_pkg::*;

    // header phases
    localparam logic [2:0] PH_HUNT     = 3'd0;
    localparam logic [2:0] PH_SECOND   = 3'd1;
    localparam logic [2:0] PH_LEN_LOW  = 3'd2;
    localparam logic [2:0] PH_LEN_HIGH = 3'd3;
    localparam logic [2:0] PH_PAYLOAD  = 3'd4;

    logic [2:0]  phase_reg, phase_next;
    logic [7:0]  first_magic_reg, first_magic_next;
    logic [7:0]  length_low_reg, length_low_next;
    logic [15:0] length_field_reg, length_field_next;
    logic [12:0] payload_rem_reg, payload_rem_next;
    logic [15:0] discard_rem_reg, discard_rem_next;

    logic [12:0] limit;
    logic [15:0] new_len;

    assign limit   = (cfg.max_payload > PAYLOAD_CAP) ? PAYLOAD_CAP : cfg.max_payload;
    assign new_len = {rx_byte, length_low_reg};

    always_comb
    begin
        phase_next        = phase_reg;
        first_magic_next  = first_magic_reg;
        length_low_next   = length_low_reg;
        length_field_next = length_field_reg;
        payload_rem_next  = payload_rem_reg;
        discard_rem_next  = discard_rem_reg;
        res_valid         = 1'b0;
        res.event_kind     = KIND_PAYLOAD;
        res.frame_type     = type_of(first_magic_reg);
        res.payload_byte   = 8'd0;
        res.last_byte      = 1'b0;
        res.payload_length = 16'd0;

        if (discard_rem_reg != 16'd0)
        begin
            discard_rem_next = discard_rem_reg - 16'd1;
        end
        else
        begin
            unique case (phase_reg)
                PH_SECOND:
                begin
                    if (!pair_ok(first_magic_reg, rx_byte))
                    begin
                        res_valid      = 1'b1;
                        res.event_kind = KIND_BAD_HEADER;
                        if (is_first(rx_byte))
                        begin
                            first_magic_next = rx_byte;
                            phase_next       = PH_SECOND;
                        end
                        else
                        begin
                            phase_next = PH_HUNT;
                        end
                    end
                    else
                    begin
                        phase_next = PH_LEN_LOW;
                    end
                end
                PH_LEN_LOW:
                begin
                    length_low_next = rx_byte;
                    phase_next      = PH_LEN_HIGH;
                end
                PH_LEN_HIGH:
                begin
                    length_field_next = new_len;
                    phase_next        = PH_HUNT;
                    if (new_len > {3'd0, limit})
                    begin
                        if (new_len <= cfg.discard_limit)
                        begin
                            discard_rem_next = new_len;
                        end
                        res_valid          = 1'b1;
                        res.event_kind     = KIND_BAD_LENGTH;
                        res.payload_length = new_len;
                    end
                    else if (new_len == 16'd0)
                    begin
                        res_valid      = 1'b1;
                        res.event_kind = KIND_EMPTY;
                        res.last_byte  = 1'b1;
                    end
                    else
                    begin
                        payload_rem_next = new_len[12:0];
                        phase_next       = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD:
                begin
                    res_valid          = 1'b1;
                    res.event_kind     = KIND_PAYLOAD;
                    res.payload_byte   = rx_byte;
                    res.payload_length = length_field_reg;
                    if (payload_rem_reg <= 13'd1)
                    begin
                        payload_rem_next = 13'd0;
                        phase_next       = PH_HUNT;
                        res.last_byte    = 1'b1;
                    end
                    else
                    begin
                        payload_rem_next = payload_rem_reg - 13'd1;
                    end
                end
                default:
                begin
                    // hunt, unused codes included
                    phase_next = PH_HUNT;
                    if (is_first(rx_byte))
                    begin
                        first_magic_next = rx_byte;
                        phase_next       = PH_SECOND;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_HUNT;
            first_magic_reg  <= 8'd0;
            length_low_reg   <= 8'd0;
            length_field_reg <= 16'd0;
            payload_rem_reg  <= 13'd0;
            discard_rem_reg  <= 16'd0;
        end
        else if (step)
        begin
            phase_reg        <= phase_next;
            first_magic_reg  <= first_magic_next;
            length_low_reg   <= length_low_next;
            length_field_reg <= length_field_next;
            payload_rem_reg  <= payload_rem_next;
            discard_rem_reg  <= discard_rem_next;
        end
    end

endmodule

// ===== sv/magic_length_frame_receiver_core.sv =====
// a result word is registered when the byte that causes it is accepted and appears in the next cycle
// throughput: one byte per cycle while in_ready is high; the output register is refilled while it is taken
// in_ready drops only while a result word waits and out_ready is low
// reset (rst_n low, asynchronous) returns to hunting for a first magic byte,
// clears the skip count and output, max_payload to 1024 and discard_limit to 4096
module magic_length_frame_receiver_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  event_kind,
    output logic [1:0]  frame_type,
    output logic [7:0]  payload_byte,
    output logic        last_byte,
    output logic [15:0] payload_length
);
    import mlfr_pkg::*;

    mlfr_cfg_t    cfg;
    mlfr_result_t res;
    mlfr_result_t out_reg;
    logic         res_valid;
    logic         out_valid_reg;
    logic         in_accept;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;

    mlfr_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mlfr_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (in_accept),
        .rx_byte   (rx_byte),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= res_valid;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_reg <= '0;
        end
        else if (in_accept && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign event_kind     = out_reg.event_kind;
    assign frame_type     = out_reg.frame_type;
    assign payload_byte   = out_reg.payload_byte;
    assign last_byte      = out_reg.last_byte;
    assign payload_length = out_reg.payload_length;

endmodule

// ===== sv/mlfr_checker.sv =====
module mlfr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  event_kind,
    input logic [1:0]  frame_type,
    input logic [7:0]  payload_byte,
    input logic        last_byte,
    input logic [15:0] payload_length
);
    import mlfr_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(event_kind) &&
            $stable(frame_type) && $stable(payload_byte) && $stable(last_byte) &&
            $stable(payload_length))
        else $error("result word changed while stalled");

    // input side never blocked by an empty output stage
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with no result pending");

    // header errors carry no byte, length or last mark
    a_bad_header_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind == KIND_BAD_HEADER |->
            payload_byte == 8'd0 && payload_length == 16'd0 && !last_byte)
        else $error("bad header word carries data");

    // empty frame marker is last with zero length
    a_empty_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind == KIND_EMPTY |->
            last_byte && payload_length == 16'd0 && payload_byte == 8'd0)
        else $error("empty frame marker malformed");

endmodule

bind magic_length_frame_receiver_core mlfr_checker u_mlfr_checker (.*);
